// File: hdl/mp4_sample_locator_unit_macros.svh
// Assertion macros used by the checker in msl_checker.sv.
`ifndef MP4_SAMPLE_LOCATOR_UNIT_MACROS_SVH
`define MP4_SAMPLE_LOCATOR_UNIT_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define MSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MSL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/msl_pkg.sv
package msl_pkg;

	typedef enum logic [2:0] {
		CMD_QUERY = 3'd0,
		CMD_RUN   = 3'd1,
		CMD_CHUNK = 3'd2,
		CMD_LEN   = 3'd3,
		CMD_SYNC  = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_BAD_CHUNK = 2'd2
	} status_code_t;

	localparam logic [1:0] CFG_TOTAL_SAMPLES = 2'd0;
	localparam logic [1:0] CFG_RUN_ENTRIES   = 2'd1;
	localparam logic [1:0] CFG_CHUNK_ENTRIES = 2'd2;
	localparam logic [1:0] CFG_SYNC_ENTRIES  = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_SYNC_RD, S_SYNC_CHK, S_RANGE, S_RUN_A, S_RUN_B, S_RUN_C,
		S_RUN_D, S_RUN_E, S_RUN_F, S_DIV, S_CHUNK_CHK, S_BASE_W, S_BASE,
		S_SUM_CHK, S_SUM_ADD, S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_SYNC_NEXT, OP_SYNC_HIT, OP_SYNC_MISS, OP_RANGE_OK,
		OP_BAD_IDX, OP_NO_RUN, OP_RUN_FIRST, OP_RUN_NEXT, OP_RUN_MUL, OP_RUN_ADV,
		OP_DIV_START, OP_DIV_STEP, OP_CHUNK_OK, OP_BAD_CHUNK, OP_BASE, OP_SUM_ADD,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic sync_empty;
		logic sync_end;
		logic sync_eq;
		logic sync_gt;
		logic idx_bad;
		logic run_end;
		logic run_match;
		logic div_last;
		logic chunk_bad;
		logic sum_end;
		logic out_free;
	} dp_stat_t;

endpackage

// File: hdl/mp4_sample_locator_unit.sv
// Channel   Handshake             Payload
// config    cfg_we                cfg_index, cfg_data
// input     in_valid / in_stall   cmd, index, start_chunk_num, per_chunk, word
// output    out_valid / out_stall status, byte_offset, byte_length, is_sync
//
// A table write word is taken without leaving the idle state, so the block stays ready.
// A query word scans the sync entries, walks the run entries, runs the bit-serial
// divider and then sums the lengths of the earlier samples in the chunk; each
// table has one read port.
// Reset is asynchronous and active low; the tables are not cleared by it.
// While out_stall holds a finished word, new writes are still taken and a query
// runs to its end, then waits for the output register to free.
module mp4_sample_locator_unit #(
	parameter int RUN_DEPTH    = 256,
	parameter int CHUNK_DEPTH  = 4096,
	parameter int SAMPLE_DEPTH = 16384,
	parameter int SYNC_DEPTH   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] index,
	input  logic [31:0] start_chunk_num,
	input  logic [31:0] per_chunk,
	input  logic [31:0] word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] byte_offset,
	output logic [31:0] byte_length,
	output logic        is_sync
);

	// The controller sequences the query steps; the datapath holds the tables,
	// the run walk arithmetic, the divider and the result register.
	msl_pkg::dp_cmd_t  ctl;
	msl_pkg::dp_stat_t stat;

	msl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	msl_dpath #(
		.RUN_DEPTH    (RUN_DEPTH),
		.CHUNK_DEPTH  (CHUNK_DEPTH),
		.SAMPLE_DEPTH (SAMPLE_DEPTH),
		.SYNC_DEPTH   (SYNC_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.index           (index),
		.start_chunk_num (start_chunk_num),
		.per_chunk       (per_chunk),
		.word            (word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.byte_offset     (byte_offset),
		.byte_length     (byte_length),
		.is_sync         (is_sync),
		.ctl             (ctl),
		.stat            (stat)
	);

endmodule

// File: hdl/msl_ctrl.sv
module msl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  msl_pkg::dp_stat_t  stat,
	output msl_pkg::dp_cmd_t   ctl
);

	msl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = msl_pkg::OP_NONE;
		in_stall = (state_q != msl_pkg::S_IDLE);
		case (state_q)
			msl_pkg::S_IDLE: begin
				if (in_valid) begin
					ctl.op = msl_pkg::OP_ACCEPT;
					if (stat.is_query) state_d = msl_pkg::S_SYNC_RD;
				end
			end
			msl_pkg::S_SYNC_RD: begin
				if (stat.sync_empty) begin
					ctl.op  = msl_pkg::OP_SYNC_HIT;
					state_d = msl_pkg::S_RANGE;
				end else if (stat.sync_end) begin
					ctl.op  = msl_pkg::OP_SYNC_MISS;
					state_d = msl_pkg::S_RANGE;
				end else begin
					state_d = msl_pkg::S_SYNC_CHK;
				end
			end
			msl_pkg::S_SYNC_CHK: begin
				if (stat.sync_eq) begin
					ctl.op  = msl_pkg::OP_SYNC_HIT;
					state_d = msl_pkg::S_RANGE;
				end else if (stat.sync_gt) begin
					ctl.op  = msl_pkg::OP_SYNC_MISS;
					state_d = msl_pkg::S_RANGE;
				end else begin
					ctl.op  = msl_pkg::OP_SYNC_NEXT;
					state_d = msl_pkg::S_SYNC_RD;
				end
			end
			msl_pkg::S_RANGE: begin
				if (stat.idx_bad) begin
					ctl.op  = msl_pkg::OP_BAD_IDX;
					state_d = msl_pkg::S_FINISH;
				end else begin
					ctl.op  = msl_pkg::OP_RANGE_OK;
					state_d = msl_pkg::S_RUN_A;
				end
			end
			msl_pkg::S_RUN_A: begin
				if (stat.run_end) begin
					ctl.op  = msl_pkg::OP_NO_RUN;
					state_d = msl_pkg::S_CHUNK_CHK;
				end else begin
					state_d = msl_pkg::S_RUN_B;
				end
			end
			msl_pkg::S_RUN_B: begin
				ctl.op  = msl_pkg::OP_RUN_FIRST;
				state_d = msl_pkg::S_RUN_C;
			end
			msl_pkg::S_RUN_C: state_d = msl_pkg::S_RUN_D;
			msl_pkg::S_RUN_D: begin
				ctl.op  = msl_pkg::OP_RUN_NEXT;
				state_d = msl_pkg::S_RUN_E;
			end
			msl_pkg::S_RUN_E: begin
				ctl.op  = msl_pkg::OP_RUN_MUL;
				state_d = msl_pkg::S_RUN_F;
			end
			msl_pkg::S_RUN_F: begin
				if (stat.run_match) begin
					ctl.op  = msl_pkg::OP_DIV_START;
					state_d = msl_pkg::S_DIV;
				end else begin
					ctl.op  = msl_pkg::OP_RUN_ADV;
					state_d = msl_pkg::S_RUN_A;
				end
			end
			msl_pkg::S_DIV: begin
				ctl.op = msl_pkg::OP_DIV_STEP;
				if (stat.div_last) state_d = msl_pkg::S_CHUNK_CHK;
			end
			msl_pkg::S_CHUNK_CHK: begin
				if (stat.chunk_bad) begin
					ctl.op  = msl_pkg::OP_BAD_CHUNK;
					state_d = msl_pkg::S_FINISH;
				end else begin
					ctl.op  = msl_pkg::OP_CHUNK_OK;
					state_d = msl_pkg::S_BASE_W;
				end
			end
			msl_pkg::S_BASE_W: state_d = msl_pkg::S_BASE;
			msl_pkg::S_BASE: begin
				ctl.op  = msl_pkg::OP_BASE;
				state_d = msl_pkg::S_SUM_CHK;
			end
			msl_pkg::S_SUM_CHK: begin
				if (stat.sum_end) state_d = msl_pkg::S_FINISH;
				else state_d = msl_pkg::S_SUM_ADD;
			end
			msl_pkg::S_SUM_ADD: begin
				ctl.op  = msl_pkg::OP_SUM_ADD;
				state_d = msl_pkg::S_SUM_CHK;
			end
			msl_pkg::S_FINISH: begin
				if (stat.out_free) begin
					ctl.op  = msl_pkg::OP_EMIT;
					state_d = msl_pkg::S_IDLE;
				end
			end
			default: state_d = msl_pkg::S_IDLE;
		endcase
	end

endmodule

// File: hdl/msl_dpath.sv
module msl_dpath #(
	parameter int RUN_DEPTH    = 256,
	parameter int CHUNK_DEPTH  = 4096,
	parameter int SAMPLE_DEPTH = 16384,
	parameter int SYNC_DEPTH   = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [2:0]        cmd,
	input  logic [31:0]       index,
	input  logic [31:0]       start_chunk_num,
	input  logic [31:0]       per_chunk,
	input  logic [31:0]       word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [31:0]       byte_offset,
	output logic [31:0]       byte_length,
	output logic              is_sync,
	input  msl_pkg::dp_cmd_t  ctl,
	output msl_pkg::dp_stat_t stat
);

	localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int RCW = $clog2(RUN_DEPTH + 1);
	localparam int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int CCW = $clog2(CHUNK_DEPTH + 1);
	localparam int LAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int YAW = (SYNC_DEPTH > 1) ? $clog2(SYNC_DEPTH) : 1;
	localparam int YCW = $clog2(SYNC_DEPTH + 1);

	// Configuration registers.
	logic [31:0] total_q;
	logic [8:0]  run_entries_q;
	logic [12:0] chunk_entries_q;
	logic [10:0] sync_entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q         <= '0;
			run_entries_q   <= '0;
			chunk_entries_q <= '0;
			sync_entries_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				msl_pkg::CFG_TOTAL_SAMPLES: total_q         <= cfg_data;
				msl_pkg::CFG_RUN_ENTRIES:   run_entries_q   <= cfg_data[8:0];
				msl_pkg::CFG_CHUNK_ENTRIES: chunk_entries_q <= cfg_data[12:0];
				msl_pkg::CFG_SYNC_ENTRIES:  sync_entries_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic [RCW-1:0] nrun;
	logic [CCW-1:0] nchunk;
	logic [YCW-1:0] nsync;
	assign nrun   = (32'(run_entries_q) < 32'(RUN_DEPTH)) ?
		RCW'(run_entries_q) : RCW'(RUN_DEPTH);
	assign nchunk = (32'(chunk_entries_q) < 32'(CHUNK_DEPTH)) ?
		CCW'(chunk_entries_q) : CCW'(CHUNK_DEPTH);
	assign nsync  = (32'(sync_entries_q) < 32'(SYNC_DEPTH)) ?
		YCW'(sync_entries_q) : YCW'(SYNC_DEPTH);

	logic accept;
	assign accept = (ctl.op == msl_pkg::OP_ACCEPT);

	// Tables; each is read every cycle at an address register.
	logic [31:0] run_start_mem [RUN_DEPTH];
	logic [31:0] run_spc_mem   [RUN_DEPTH];
	logic [31:0] chunk_mem     [CHUNK_DEPTH];
	logic [31:0] len_mem       [SAMPLE_DEPTH];
	logic [31:0] sync_mem      [SYNC_DEPTH];

	logic [RAW-1:0] run_addr_q;
	logic [CAW-1:0] chunk_addr_q;
	logic [LAW-1:0] len_addr_q;
	logic [YCW-1:0] sync_i_q;
	logic [31:0]    start_rd_q, spc_rd_q, chunk_rd_q, len_rd_q, sync_rd_q;

	always_ff @(posedge clk) begin
		if (accept && cmd == msl_pkg::CMD_RUN && index < 32'(RUN_DEPTH)) begin
			run_start_mem[index[RAW-1:0]] <= start_chunk_num;
			run_spc_mem[index[RAW-1:0]]   <= per_chunk;
		end
		start_rd_q <= run_start_mem[run_addr_q];
		spc_rd_q   <= run_spc_mem[run_addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == msl_pkg::CMD_CHUNK && index < 32'(CHUNK_DEPTH))
			chunk_mem[index[CAW-1:0]] <= word;
		chunk_rd_q <= chunk_mem[chunk_addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == msl_pkg::CMD_LEN && index < 32'(SAMPLE_DEPTH))
			len_mem[index[LAW-1:0]] <= word;
		len_rd_q <= len_mem[len_addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == msl_pkg::CMD_SYNC && index < 32'(SYNC_DEPTH))
			sync_mem[index[YAW-1:0]] <= word;
		sync_rd_q <= sync_mem[sync_i_q[YAW-1:0]];
	end

	// Query working registers.
	logic [31:0]    idx_q, first_q, spc_q, diff_q, rem_q, quo_q, offset_q, len_q;
	logic [31:0]    sum_i_q, s_q;
	logic [63:0]    so_far_q, prod_q;
	logic [RCW-1:0] run_i_q;
	logic [4:0]     div_cnt_q;
	logic [1:0]     status_q;
	logic           flag_q;

	logic [31:0] num, span_end, chunk, pos, first_sample;
	logic [32:0] div_trial;
	logic        div_ge;
	assign num          = idx_q + 32'd1;
	assign span_end     = (32'(run_i_q) + 32'd1 < 32'(nrun)) ?
		start_rd_q - 32'd1 : 32'(nchunk);
	assign chunk        = first_q + quo_q;
	assign pos          = idx_q - so_far_q[31:0];
	assign first_sample = idx_q - rem_q;
	assign div_trial    = {rem_q, quo_q[31]};
	assign div_ge       = (div_trial >= {1'b0, spc_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_addr_q   <= '0;
			chunk_addr_q <= '0;
			len_addr_q   <= '0;
			sync_i_q     <= '0;
			run_i_q      <= '0;
			div_cnt_q    <= '0;
		end else begin
			case (ctl.op)
				msl_pkg::OP_ACCEPT: begin
					sync_i_q   <= '0;
					len_addr_q <= index[LAW-1:0];
				end
				msl_pkg::OP_SYNC_NEXT: sync_i_q <= sync_i_q + YCW'(1);
				msl_pkg::OP_RANGE_OK: begin
					run_addr_q <= '0;
					run_i_q    <= '0;
				end
				msl_pkg::OP_RUN_FIRST: run_addr_q <= RAW'(32'(run_i_q) + 32'd1);
				msl_pkg::OP_RUN_ADV: begin
					run_i_q    <= run_i_q + RCW'(1);
					run_addr_q <= RAW'(32'(run_i_q) + 32'd1);
				end
				msl_pkg::OP_DIV_START: div_cnt_q <= '0;
				msl_pkg::OP_DIV_STEP:  div_cnt_q <= div_cnt_q + 5'd1;
				msl_pkg::OP_CHUNK_OK:  chunk_addr_q <= chunk[CAW-1:0];
				msl_pkg::OP_BASE:      len_addr_q <= first_sample[LAW-1:0];
				msl_pkg::OP_SUM_ADD:   len_addr_q <= LAW'(s_q + 32'd1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			msl_pkg::OP_ACCEPT: begin
				idx_q    <= index;
				status_q <= msl_pkg::ST_OK;
				offset_q <= '0;
				len_q    <= '0;
			end
			msl_pkg::OP_SYNC_HIT:  flag_q <= 1'b1;
			msl_pkg::OP_SYNC_MISS: flag_q <= 1'b0;
			msl_pkg::OP_RANGE_OK: begin
				len_q    <= len_rd_q;
				so_far_q <= '0;
			end
			msl_pkg::OP_BAD_IDX: status_q <= msl_pkg::ST_BAD_INDEX;
			msl_pkg::OP_NO_RUN: begin
				first_q <= '0;
				quo_q   <= '0;
				rem_q   <= '0;
			end
			msl_pkg::OP_RUN_FIRST: begin
				first_q <= start_rd_q - 32'd1;
				spc_q   <= spc_rd_q;
			end
			msl_pkg::OP_RUN_NEXT: diff_q <= span_end - first_q;
			msl_pkg::OP_RUN_MUL:  prod_q <= 64'(diff_q) * 64'(spc_q);
			msl_pkg::OP_RUN_ADV:  so_far_q <= so_far_q + prod_q;
			msl_pkg::OP_DIV_START: begin
				rem_q <= '0;
				quo_q <= pos;
			end
			msl_pkg::OP_DIV_STEP: begin
				rem_q <= div_ge ? 32'(div_trial - {1'b0, spc_q}) : div_trial[31:0];
				quo_q <= {quo_q[30:0], div_ge};
			end
			msl_pkg::OP_BAD_CHUNK: status_q <= msl_pkg::ST_BAD_CHUNK;
			msl_pkg::OP_BASE: begin
				offset_q <= chunk_rd_q;
				sum_i_q  <= '0;
				s_q      <= first_sample;
			end
			msl_pkg::OP_SUM_ADD: begin
				if (s_q < total_q && s_q < 32'(SAMPLE_DEPTH))
					offset_q <= offset_q + len_rd_q;
				sum_i_q <= sum_i_q + 32'd1;
				s_q     <= s_q + 32'd1;
			end
			default: ;
		endcase
	end

	// Output register.
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == msl_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == msl_pkg::OP_EMIT) begin
			status      <= status_q;
			byte_offset <= offset_q;
			byte_length <= len_q;
			is_sync     <= flag_q;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.is_query   = (cmd == msl_pkg::CMD_QUERY);
	assign stat.sync_empty = (sync_entries_q == '0);
	assign stat.sync_end   = (sync_i_q == nsync);
	assign stat.sync_eq    = (sync_rd_q == num);
	assign stat.sync_gt    = (sync_rd_q > num);
	assign stat.idx_bad    = (idx_q >= total_q) || (idx_q >= 32'(SAMPLE_DEPTH));
	assign stat.run_end    = (run_i_q == nrun);
	assign stat.run_match  = ((so_far_q + prod_q) > 64'(idx_q)) && (spc_q != '0);
	assign stat.div_last   = (div_cnt_q == 5'd31);
	assign stat.chunk_bad  = (chunk >= 32'(nchunk));
	assign stat.sum_end    = (sum_i_q == rem_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

// File: hdl/msl_checker.sv
`include "mp4_sample_locator_unit_macros.svh"

module msl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  cmd,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] byte_offset,
	input logic [31:0] byte_length
);

	logic write_taken;
	assign write_taken = in_valid && !in_stall && (cmd != msl_pkg::CMD_QUERY);

	// A stalled result word stays offered.
	`MSL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result word dropped")

	// A table write finishes at once, so the next word is taken right away.
	`MSL_ASSERT(a_write_fast, write_taken |=> !in_stall, "write stalled")

	// No offset is reported with an error status.
	`MSL_ASSERT(a_err_offset, out_valid && status != msl_pkg::ST_OK |-> byte_offset == 32'd0, "offset on error")

	// A bad sample index carries no length.
	`MSL_ASSERT(a_bad_len, out_valid && status == msl_pkg::ST_BAD_INDEX |-> byte_length == 32'd0, "length on bad index")

	// Reset leaves the block idle and ready for a word, with no result offered.
	`MSL_ASSERT_ALWAYS(a_reset_ready, !arst_n |=> !in_stall && !out_valid, "busy in reset")

endmodule

bind mp4_sample_locator_unit msl_checker u_msl_checker (.*);

// File: bench/mp4_sample_locator_unit_checker.sv
`timescale 1ns / 100ps
module mp4_sample_locator_unit_checker
	import msl_pkg::*;
#(
	parameter int RUN_DEPTH    = 256,
	parameter int CHUNK_DEPTH  = 4096,
	parameter int SAMPLE_DEPTH = 16384,
	parameter int SYNC_DEPTH   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] index,
	input  logic [31:0] start_chunk_num,
	input  logic [31:0] per_chunk,
	input  logic [31:0] word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] byte_offset,
	input  logic [31:0] byte_length,
	input  logic        is_sync,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] offset;
		logic [31:0] length;
		logic        key;
	} location_t;

	logic [31:0] track_samples;
	logic [8:0]  run_count;
	logic [12:0] chunk_count;
	logic [10:0] sync_count;

	logic [31:0] run_first_chunk [RUN_DEPTH];
	logic [31:0] run_spc         [RUN_DEPTH];
	logic [31:0] chunk_base      [CHUNK_DEPTH];
	logic [31:0] sample_len      [SAMPLE_DEPTH];
	logic [31:0] sync_number     [SYNC_DEPTH];

	location_t pending_locations [$];

	// Computes the location, length and keyframe flag of one sample.
	function automatic location_t locate_sample(input logic [31:0] idx);
		location_t   loc;
		logic [31:0] num, first, spc, nxt, span, pos, chunk, in_chunk, sample;
		logic [63:0] so_far, in_run;
		int          nrun, nchunk, nsync;
		loc = '0;
		num = idx + 32'd1;
		nsync = (sync_count > SYNC_DEPTH) ? SYNC_DEPTH : int'(sync_count);
		if (sync_count == '0) begin
			loc.key = 1'b1;
		end else begin
			for (int i = 0; i < nsync; i++) begin
				if (sync_number[i] == num) begin
					loc.key = 1'b1;
					break;
				end
				if (sync_number[i] > num)
					break;
			end
		end
		if (idx >= track_samples || idx >= 32'(SAMPLE_DEPTH)) begin
			loc.status = ST_BAD_INDEX;
			return loc;
		end
		loc.length = sample_len[idx];
		nrun = (run_count > RUN_DEPTH) ? RUN_DEPTH : int'(run_count);
		nchunk = (chunk_count > CHUNK_DEPTH) ? CHUNK_DEPTH : int'(chunk_count);
		so_far = '0;
		chunk = '0;
		in_chunk = '0;
		for (int i = 0; i < nrun; i++) begin
			first = run_first_chunk[i] - 32'd1;
			spc = run_spc[i];
			nxt = (i + 1 < nrun) ? run_first_chunk[i + 1] - 32'd1 : 32'(nchunk);
			span = nxt - first;
			in_run = {32'b0, span} * {32'b0, spc};
			if ((so_far + in_run > {32'b0, idx}) && spc != '0) begin
				pos = idx - so_far[31:0];
				chunk = first + pos / spc;
				in_chunk = pos % spc;
				break;
			end
			so_far = so_far + in_run;
		end
		if (chunk >= 32'(nchunk)) begin
			loc.status = ST_BAD_CHUNK;
			return loc;
		end
		loc.offset = chunk_base[chunk];
		for (logic [31:0] k = 0; k < in_chunk; k++) begin
			sample = idx - in_chunk + k;
			if (sample < track_samples && sample < 32'(SAMPLE_DEPTH))
				loc.offset = loc.offset + sample_len[sample];
		end
		return loc;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : monitor
		location_t want;
		if (!arst_n) begin
			track_samples = '0;
			run_count = '0;
			chunk_count = '0;
			sync_count = '0;
			failures = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOTAL_SAMPLES: track_samples = cfg_data;
					CFG_RUN_ENTRIES:   run_count = cfg_data[8:0];
					CFG_CHUNK_ENTRIES: chunk_count = cfg_data[12:0];
					CFG_SYNC_ENTRIES:  sync_count = cfg_data[10:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_QUERY: pending_locations.push_back(locate_sample(index));
					CMD_RUN: begin
						if (index < 32'(RUN_DEPTH)) begin
							run_first_chunk[index] = start_chunk_num;
							run_spc[index] = per_chunk;
						end
					end
					CMD_CHUNK: if (index < 32'(CHUNK_DEPTH)) chunk_base[index] = word;
					CMD_LEN:   if (index < 32'(SAMPLE_DEPTH)) sample_len[index] = word;
					CMD_SYNC:  if (index < 32'(SYNC_DEPTH)) sync_number[index] = word;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_locations.size() == 0) begin
					$error("result word with no query waiting");
					failures++;
				end else begin
					want = pending_locations.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("byte_offset", want.offset, byte_offset);
					check_field("byte_length", want.length, byte_length);
					check_field("is_sync", 32'(want.key), 32'(is_sync));
				end
			end
		end
		outstanding = pending_locations.size();
	end

endmodule

// File: bench/mp4_sample_locator_unit_test.sv
`timescale 1ns / 100ps
module mp4_sample_locator_unit_test;
	import msl_pkg::*;

	localparam int RUN_DEPTH    = 256;
	localparam int CHUNK_DEPTH  = 4096;
	localparam int SAMPLE_DEPTH = 16384;
	localparam int SYNC_DEPTH   = 1024;

	// The quiet-cycle limit is meant to cover the longest query, which walks every
	// run and then sums the lengths of the earlier samples in its chunk.
	localparam int QUIET_LIMIT = 20000;
	localparam int TOTAL_WORDS = 1550;
	// Cap on the contiguous prefix of sample lengths that gets loaded.
	localparam int LEN_CAP = 600;

	// Command codes 5 through 7 are unused and must be dropped by the block.
	localparam logic [2:0] CMD_UNUSED_FIRST = CMD_SYNC + 3'd1;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = CMD_QUERY;
	logic [31:0] index = '0;
	logic [31:0] start_chunk_num = '0;
	logic [31:0] per_chunk = '0;
	logic [31:0] word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] byte_offset;
	logic [31:0] byte_length;
	logic        is_sync;

	int failures;
	int outstanding;

	// When set, both sides run back to back with no idle cycles.
	bit no_idle = 1'b0;
	// Sample lengths 0 .. len_ready-1 have been written at least once.
	int len_ready = 0;
	// Counts every word sent on the input channel.
	int sent_words = 0;
	int quiet = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mp4_sample_locator_unit u_dut (.*);

	mp4_sample_locator_unit_checker u_checker (.*);

	// Any cycle with a handshake or a register write restarts the watchdog.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("** mp4_sample_locator_unit: FAILED **");
			$finish;
		end
	end

	// The result side takes a word, then holds off for a random number of cycles.
	always begin : result_sink
		int hold;
		@(posedge clk);
		if (out_valid && !out_stall) begin
			hold = no_idle ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Presents one word after a random gap and returns at the edge that takes it.
	// The valid is left high so that a back-to-back word needs no second write
	// to it in the same step.
	task automatic push_word(input logic [2:0] c, input logic [31:0] idx,
			input logic [31:0] first, input logic [31:0] spc, input logic [31:0] w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		index <= idx;
		start_chunk_num <= first;
		per_chunk <= spc;
		word <= w;
		do @(posedge clk); while (in_stall);
		sent_words++;
	endtask

	// Waits until every query has answered, then gives a trailing table write
	// time to land.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes all four registers in consecutive cycles; the block must be idle.
	task automatic set_config(input logic [31:0] total, input int runs, input int chunks,
			input int syncs);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOTAL_SAMPLES;
		cfg_data <= total;
		@(posedge clk);
		cfg_index <= CFG_RUN_ENTRIES;
		cfg_data <= 32'(runs);
		@(posedge clk);
		cfg_index <= CFG_CHUNK_ENTRIES;
		cfg_data <= 32'(chunks);
		@(posedge clk);
		cfg_index <= CFG_SYNC_ENTRIES;
		cfg_data <= 32'(syncs);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One phase: program the registers, load every table entry that a query can
	// touch, then mix queries with ignored words. A tidy phase builds ascending
	// runs, chunk bases and sync numbers the way a real file would; an untidy one
	// fills the tables with raw random values.
	task automatic run_phase(input logic [31:0] total, input int runs, input int chunks,
			input int syncs, input int queries, input bit tidy);
		int          nrun, nchunk, nsync, avail, target, in_range, pick;
		logic [31:0] first, base, num, q;
		settle();
		set_config(total, runs, chunks, syncs);
		nrun = (runs > RUN_DEPTH) ? RUN_DEPTH : runs;
		nchunk = (chunks > CHUNK_DEPTH) ? CHUNK_DEPTH : chunks;
		nsync = (syncs > SYNC_DEPTH) ? SYNC_DEPTH : syncs;
		avail = (total > 32'(SAMPLE_DEPTH)) ? SAMPLE_DEPTH : int'(total);

		first = tidy ? 32'd1 : $urandom;
		for (int k = 0; k < nrun; k++) begin
			push_word(CMD_RUN, 32'(k), first,
				tidy ? (($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, 6)) : $urandom,
				$urandom);
			first = tidy ? first + $urandom_range(1, 4) : $urandom;
		end

		base = $urandom;
		for (int k = 0; k < nchunk; k++) begin
			push_word(CMD_CHUNK, 32'(k), $urandom, $urandom, base);
			base = tidy ? base + $urandom_range(0, 4000) : $urandom;
		end

		// Only a prefix of the sample lengths is ever loaded; queries inside the
		// sample range stay below it so that no unloaded entry gets read.
		target = (avail < LEN_CAP) ? avail : LEN_CAP;
		while (len_ready < target) begin
			push_word(CMD_LEN, 32'(len_ready), $urandom, $urandom,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 2000));
			len_ready++;
		end
		if (len_ready > 0) begin
			repeat (3)
				push_word(CMD_LEN, $urandom_range(0, len_ready - 1), $urandom, $urandom, $urandom);
		end

		num = $urandom_range(0, 3);
		for (int k = 0; k < nsync; k++) begin
			num = tidy ? num + $urandom_range(1, 12) : $urandom;
			push_word(CMD_SYNC, 32'(k), $urandom, $urandom, num);
		end

		in_range = (avail < len_ready) ? avail : len_ready;
		for (int k = 0; k < queries; k++) begin
			if ($urandom_range(0, 29) == 0)
				settle();
			pick = $urandom_range(0, 9);
			if (pick == 9) begin
				// Unused commands and stray writes; the latter mostly land past
				// a table's depth.
				push_word(3'($urandom_range(CMD_RUN, CMD_UNUSED_LAST)), $urandom, $urandom,
					$urandom, $urandom);
				k--;
				continue;
			end
			if (pick < 7 && in_range > 0)
				q = $urandom_range(0, in_range - 1);
			else if (pick == 7)
				q = $urandom | 32'(SAMPLE_DEPTH);
			else if (total <= 32'(SAMPLE_DEPTH))
				q = total;
			else
				q = 32'hFFFF_FFFF;
			push_word(CMD_QUERY, q, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin : stimulus
		logic [31:0] total;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tiny hand-built track: two runs (two chunks of two samples, then one
		// chunk of three), a chunk base near the top to force offset wrap, an
		// all-ones length and two sync samples. Sample 7 lies past every run and
		// falls back to chunk 0.
		set_config(32'd8, 2, 3, 2);
		push_word(CMD_RUN, 32'd0, 32'd1, 32'd2, '0);
		push_word(CMD_RUN, 32'd1, 32'd3, 32'd3, '0);
		push_word(CMD_CHUNK, 32'd0, '0, '0, 32'd100);
		push_word(CMD_CHUNK, 32'd1, '0, '0, 32'd200);
		push_word(CMD_CHUNK, 32'd2, '0, '0, 32'hFFFF_FFF0);
		push_word(CMD_LEN, 32'd0, '0, '0, 32'hFFFF_FFFF);
		for (int k = 1; k < 8; k++)
			push_word(CMD_LEN, 32'(k), '0, '0, 32'(k * 10));
		len_ready = 8;
		push_word(CMD_SYNC, 32'd0, '0, '0, 32'd1);
		push_word(CMD_SYNC, 32'd1, '0, '0, 32'd5);
		push_word(CMD_QUERY, 32'd0, '0, '0, '0);
		push_word(CMD_QUERY, 32'd1, '0, '0, '0);
		push_word(CMD_QUERY, 32'd4, '0, '0, '0);
		push_word(CMD_QUERY, 32'd6, '0, '0, '0);
		push_word(CMD_QUERY, 32'd7, '0, '0, '0);
		push_word(CMD_QUERY, 32'd8, '0, '0, '0);
		push_word(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(CMD_UNUSED_FIRST, 32'd0, '0, '0, 32'hFFFF_FFFF);
		push_word(CMD_UNUSED_LAST, 32'd0, '0, '0, 32'hFFFF_FFFF);
		push_word(CMD_LEN, 32'(SAMPLE_DEPTH), '0, '0, 32'hDEAD_BEEF);
		push_word(CMD_QUERY, 32'd0, '0, '0, '0);

		// Register extremes: an empty track, then a run count above the table
		// depth with the full run table loaded back to back.
		run_phase('0, 0, 0, 0, 6, 1'b1);
		no_idle = 1'b1;
		run_phase(32'hFFFF_FFFF, 511, 64, 40, 8, 1'b1);
		no_idle = 1'b0;
		run_phase(32'd5, 1, 1, 0, 10, 1'b1);

		while (sent_words < TOTAL_WORDS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			total = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 300);
			run_phase(total, $urandom_range(0, 8), $urandom_range(0, 40),
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16),
				$urandom_range(10, 40), $urandom_range(0, 3) != 0);
		end

		settle();
		repeat (64) @(posedge clk);
		if (failures == 0)
			$display("** mp4_sample_locator_unit: PASSED **");
		else
			$display("** mp4_sample_locator_unit: FAILED **");
		$finish;
	end

endmodule

// File: mp4_sample_locator_unit.f
+incdir+hdl
hdl/msl_pkg.sv
hdl/msl_ctrl.sv
hdl/msl_dpath.sv
hdl/mp4_sample_locator_unit.sv
hdl/msl_checker.sv
bench/mp4_sample_locator_unit_checker.sv
bench/mp4_sample_locator_unit_test.sv
